[rtl/cafa_pkg.sv]
// cafa_pkg: shared types and constants for the contact aware force amplifier.
// Register indexes, reset values and the result record used by the top level
// and its checker.
`timescale 1ns / 1ps

package cafa_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  typedef enum logic [CFG_AW-1:0] {
    REG_ASSIST_ENABLE = 3'd0,
    REG_FORCE_GAIN    = 3'd1,
    REG_TORQUE_GAIN   = 3'd2,
    REG_FORCE_LIMIT   = 3'd3,
    REG_TORQUE_LIMIT  = 3'd4,
    REG_THRESH_IN     = 3'd5,
    REG_THRESH_FREE   = 3'd6,
    REG_FILTER_ALPHA  = 3'd7
  } cfg_reg_t;

  localparam logic signed [15:0] FORCE_GAIN_RST   = -16'sd384;
  localparam logic signed [15:0] TORQUE_GAIN_RST  = 16'sd0;
  localparam logic        [14:0] FORCE_LIMIT_RST  = 15'd10000;
  localparam logic        [14:0] TORQUE_LIMIT_RST = 15'd250;
  localparam logic signed [15:0] THRESH_IN_RST    = -16'sd20;
  localparam logic signed [15:0] THRESH_FREE_RST  = -16'sd100;
  localparam logic        [8:0]  FILTER_ALPHA_RST = 9'd205;
  localparam logic signed [15:0] ACTIVE_THR_RST   = -16'sd50;
  localparam logic        [15:0] APPLIED_STIFF_RST = 16'd1;

  localparam logic [15:0] CONTACT_STIFFNESS = 16'd4000;
  localparam logic [8:0]  ALPHA_ONE         = 9'd256;

  typedef struct packed {
    logic               command_valid;
    logic signed [15:0] add_force_x;
    logic signed [15:0] add_force_y;
    logic signed [15:0] add_force_z;
    logic signed [15:0] add_torque_x;
    logic signed [15:0] add_torque_y;
    logic signed [15:0] add_torque_z;
    logic        [15:0] stiffness_z_out;
    logic               in_contact;
    logic               impedance_update;
    logic               mode_request;
  } cafa_res_t;

endpackage

[rtl/cafa_axis.sv]
// cafa_axis: one wrench axis: sample times Q8.8 gain, rounded, limit check.
// Depends on cafa_pkg for the default sample width.
`timescale 1ns / 1ps

module cafa_axis
  import cafa_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [15:0]             gain,
  input  logic        [14:0]             limit,
  input  logic                           kill,
  output logic signed [15:0]             result
);

  localparam int unsigned PW = SAMPLE_WIDTH + 16;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] scaled;
  logic signed [PW-1:0] mag;
  logic                 over;

  always_comb begin
    prod   = PW'(sample) * PW'(gain);
    // round to nearest, halves toward plus infinity
    scaled = (prod + PW'(128)) >>> 8;
    mag    = scaled[PW-1] ? -scaled : scaled;
    over   = mag > $signed({{(PW-15){1'b0}}, limit});
    result = (over || kill) ? 16'sd0 : scaled[15:0];
  end

endmodule

[rtl/contact_aware_force_amplifier_unit.sv]
// contact_aware_force_amplifier_unit: top level of the force amplifier.
// Uses cafa_pkg and six cafa_axis instances.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one control tick: mode flag,
//   tool z force, wrist force and torque vectors and commanded z stiffness.
//   Result channel (out_valid / out_stall) returns exactly one result per tick.
//   The cfg_ port writes the eight registers; write only while idle.
// Timing:
//   An item is registered on transfer; its result moves into the output
//   register, raising out_valid, once that register is empty or read out.
//   One item per cycle is sustained while out_stall is low; the filter,
//   contact state and applied stiffness update as the item moves into the output register.
// Reset (rst_n low, synchronous): both stages empty, registers to defaults,
//   bias and filter cleared, threshold -0.5 N, applied stiffness 1.
// Stall: while out_stall holds the result, one more item is still taken into
//   the input register; after that in_stall is raised until the result moves.
`timescale 1ns / 1ps

module contact_aware_force_amplifier_unit
  import cafa_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [CFG_AW-1:0]              cfg_index,
  input  logic [CFG_DW-1:0]              cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_tool_force_z,
  input  logic signed [SAMPLE_WIDTH-1:0] in_wrist_force_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_wrist_force_y,
  input  logic signed [SAMPLE_WIDTH-1:0] in_wrist_force_z,
  input  logic signed [SAMPLE_WIDTH-1:0] in_wrist_torque_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_wrist_torque_y,
  input  logic signed [SAMPLE_WIDTH-1:0] in_wrist_torque_z,
  input  logic [15:0]                    in_commanded_stiffness_z,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_command_valid,
  output logic signed [15:0]             out_add_force_x,
  output logic signed [15:0]             out_add_force_y,
  output logic signed [15:0]             out_add_force_z,
  output logic signed [15:0]             out_add_torque_x,
  output logic signed [15:0]             out_add_torque_y,
  output logic signed [15:0]             out_add_torque_z,
  output logic [15:0]                    out_stiffness_z_out,
  output logic                           out_in_contact,
  output logic                           out_impedance_update,
  output logic                           out_mode_request
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned FW = SW + 11;              // filter accumulator
  localparam int unsigned CW = (SW > 16) ? SW : 16;  // threshold compare
  localparam logic signed [SW:0] SAT_HI = (SW+1)'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SW:0] SAT_LO = -SAT_HI - (SW+1)'(1);

  // configuration registers
  logic               assist_enable_r;
  logic signed [15:0] force_gain_r;
  logic signed [15:0] torque_gain_r;
  logic        [14:0] force_limit_r;
  logic        [14:0] torque_limit_r;
  logic signed [15:0] thresh_in_r;
  logic signed [15:0] thresh_free_r;
  logic        [8:0]  filter_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assist_enable_r <= 1'b0;
      force_gain_r    <= FORCE_GAIN_RST;
      torque_gain_r   <= TORQUE_GAIN_RST;
      force_limit_r   <= FORCE_LIMIT_RST;
      torque_limit_r  <= TORQUE_LIMIT_RST;
      thresh_in_r     <= THRESH_IN_RST;
      thresh_free_r   <= THRESH_FREE_RST;
      filter_alpha_r  <= FILTER_ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ASSIST_ENABLE: assist_enable_r <= cfg_wdata[0];
        REG_FORCE_GAIN:    force_gain_r    <= cfg_wdata;
        REG_TORQUE_GAIN:   torque_gain_r   <= cfg_wdata;
        REG_FORCE_LIMIT:   force_limit_r   <= cfg_wdata[14:0];
        REG_TORQUE_LIMIT:  torque_limit_r  <= cfg_wdata[14:0];
        REG_THRESH_IN:     thresh_in_r     <= cfg_wdata;
        REG_THRESH_FREE:   thresh_free_r   <= cfg_wdata;
        REG_FILTER_ALPHA:  filter_alpha_r  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                  s1_valid_r;
  logic                  s1_ready_r;
  logic signed [SW-1:0]  s1_tool_z_r;
  logic signed [SW-1:0]  s1_wrench_r [6];
  logic [15:0]           s1_stiff_r;
  logic                  s1_adv;
  logic                  in_xfer;

  assign s1_adv   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ready_r     <= in_mode_ready;
      s1_tool_z_r    <= in_tool_force_z;
      s1_wrench_r[0] <= in_wrist_force_x;
      s1_wrench_r[1] <= in_wrist_force_y;
      s1_wrench_r[2] <= in_wrist_force_z;
      s1_wrench_r[3] <= in_wrist_torque_x;
      s1_wrench_r[4] <= in_wrist_torque_y;
      s1_wrench_r[5] <= in_wrist_torque_z;
      s1_stiff_r     <= in_commanded_stiffness_z;
    end
  end

  // tick state
  logic signed [SW-1:0] bias_r, bias_nxt;
  logic                 bias_taken_r, bias_taken_nxt;
  logic signed [SW-1:0] filt_r, filt_nxt;
  logic signed [15:0]   active_thr_r, active_thr_nxt;
  logic [15:0]          applied_stiff_r, applied_stiff_nxt;
  logic                 req_sent_r, req_sent_nxt;

  // datapath
  logic signed [SW-1:0] bias_eff;
  logic signed [SW-1:0] filt_old;
  logic signed [SW:0]   diff_w;
  logic signed [SW-1:0] diff;
  logic        [8:0]    alpha_c;
  logic        [8:0]    alpha_inv;
  logic signed [FW-1:0] acc;
  logic signed [FW-1:0] acc_rnd;
  logic signed [SW-1:0] filt_new;
  logic                 contact;
  logic [15:0]          stiff;
  logic signed [15:0]   axis_res [6];
  cafa_res_t            res_nxt;
  cafa_res_t            res_r;

  always_comb begin
    bias_eff  = bias_taken_r ? bias_r : s1_tool_z_r;
    filt_old  = bias_taken_r ? filt_r : '0;
    diff_w    = (SW+1)'(s1_tool_z_r) - (SW+1)'(bias_eff);
    if (diff_w > SAT_HI) begin
      diff = SAT_HI[SW-1:0];
    end else if (diff_w < SAT_LO) begin
      diff = SAT_LO[SW-1:0];
    end else begin
      diff = diff_w[SW-1:0];
    end
    alpha_c   = filter_alpha_r[8] ? ALPHA_ONE : filter_alpha_r;
    alpha_inv = ALPHA_ONE - alpha_c;
    acc       = FW'($signed({1'b0, alpha_c})) * FW'(filt_old)
              + FW'($signed({1'b0, alpha_inv})) * FW'(diff);
    acc_rnd   = (acc + FW'(128)) >>> 8;
    // weighted mean of two in-range values stays in range
    filt_new  = acc_rnd[SW-1:0];
    contact   = $signed(CW'(filt_new)) < $signed(CW'(active_thr_r));
    stiff     = contact ? CONTACT_STIFFNESS : s1_stiff_r;
  end

  for (genvar g = 0; g < 6; g++) begin : g_axis
    cafa_axis #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_axis (
      .sample(s1_wrench_r[g]),
      .gain  ((g < 3) ? force_gain_r : torque_gain_r),
      .limit ((g < 3) ? force_limit_r : torque_limit_r),
      .kill  (contact && (g >= 2)),
      .result(axis_res[g])
    );
  end

  always_comb begin
    bias_nxt          = bias_r;
    bias_taken_nxt    = bias_taken_r;
    filt_nxt          = filt_r;
    active_thr_nxt    = active_thr_r;
    applied_stiff_nxt = applied_stiff_r;
    req_sent_nxt      = req_sent_r;
    res_nxt           = '0;
    if (assist_enable_r) begin
      if (!s1_ready_r) begin
        res_nxt.mode_request = !req_sent_r;
        req_sent_nxt         = 1'b1;
      end else begin
        bias_nxt                 = bias_eff;
        bias_taken_nxt           = 1'b1;
        filt_nxt                 = filt_new;
        active_thr_nxt           = contact ? thresh_in_r : thresh_free_r;
        applied_stiff_nxt        = stiff;
        res_nxt.command_valid    = 1'b1;
        res_nxt.add_force_x      = axis_res[0];
        res_nxt.add_force_y      = axis_res[1];
        res_nxt.add_force_z      = axis_res[2];
        res_nxt.add_torque_x     = axis_res[3];
        res_nxt.add_torque_y     = axis_res[4];
        res_nxt.add_torque_z     = axis_res[5];
        res_nxt.stiffness_z_out  = stiff;
        res_nxt.in_contact       = contact;
        res_nxt.impedance_update = stiff != applied_stiff_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r          <= '0;
      bias_taken_r    <= 1'b0;
      filt_r          <= '0;
      active_thr_r    <= ACTIVE_THR_RST;
      applied_stiff_r <= APPLIED_STIFF_RST;
      req_sent_r      <= 1'b0;
    end else if (s1_adv) begin
      bias_r          <= bias_nxt;
      bias_taken_r    <= bias_taken_nxt;
      filt_r          <= filt_nxt;
      active_thr_r    <= active_thr_nxt;
      applied_stiff_r <= applied_stiff_nxt;
      req_sent_r      <= req_sent_nxt;
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_command_valid    = res_r.command_valid;
  assign out_add_force_x      = res_r.add_force_x;
  assign out_add_force_y      = res_r.add_force_y;
  assign out_add_force_z      = res_r.add_force_z;
  assign out_add_torque_x     = res_r.add_torque_x;
  assign out_add_torque_y     = res_r.add_torque_y;
  assign out_add_torque_z     = res_r.add_torque_z;
  assign out_stiffness_z_out  = res_r.stiffness_z_out;
  assign out_in_contact       = res_r.in_contact;
  assign out_impedance_update = res_r.impedance_update;
  assign out_mode_request     = res_r.mode_request;

endmodule

[rtl/cafa_chk.sv]
// cafa_chk: port-level checker for the force amplifier result channel.
// Depends on cafa_pkg; bound to contact_aware_force_amplifier_unit below.
`timescale 1ns / 1ps

module cafa_chk
  import cafa_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_command_valid,
  input logic signed [15:0] out_add_force_x,
  input logic signed [15:0] out_add_force_y,
  input logic signed [15:0] out_add_force_z,
  input logic signed [15:0] out_add_torque_x,
  input logic signed [15:0] out_add_torque_y,
  input logic signed [15:0] out_add_torque_z,
  input logic [15:0]        out_stiffness_z_out,
  input logic               out_in_contact,
  input logic               out_impedance_update,
  input logic               out_mode_request
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_add_force_x)
      && $stable(out_stiffness_z_out) && $stable(out_command_valid))
    else $error("result changed while stalled");

  // no command means an all-zero wrench and stiffness, and no contact or update flag
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_command_valid |-> out_add_force_x == 16'sd0
      && out_add_force_y == 16'sd0 && out_add_force_z == 16'sd0
      && out_add_torque_x == 16'sd0 && out_add_torque_y == 16'sd0
      && out_add_torque_z == 16'sd0 && out_stiffness_z_out == 16'd0
      && !out_in_contact && !out_impedance_update)
    else $error("nonzero payload without a command");

  // contact forces the stiff z axis and a zero z force and torque set
  a_contact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_contact |-> out_command_valid
      && out_stiffness_z_out == CONTACT_STIFFNESS && out_add_force_z == 16'sd0
      && out_add_torque_x == 16'sd0 && out_add_torque_y == 16'sd0
      && out_add_torque_z == 16'sd0)
    else $error("contact result not clamped");

  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_request |-> !out_command_valid)
    else $error("mode request together with a command");

endmodule

bind contact_aware_force_amplifier_unit cafa_chk u_cafa_chk (.*);

[verif/contact_aware_force_amplifier_unit_test.sv]
// Self-checking testbench for contact_aware_force_amplifier_unit.
// Drives control ticks with random pacing, predicts each added wrench with its own
// model of the block, and compares every result transfer. Depends on cafa_pkg.
`timescale 1ns / 1ps

module contact_aware_force_amplifier_unit_test;
  import cafa_pkg::*;

  localparam int unsigned TIMEOUT_NS = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct {
    bit                 mode_ready;
    logic signed [15:0] tool_z;
    logic signed [15:0] wrench [6];  // force x/y/z, torque x/y/z
    logic [15:0]        stiff_cmd;
  } tick_t;

  // raw register words as written on the config port
  typedef struct {
    logic [15:0] assist, fgain, tgain, flim, tlim, thr_in, thr_free, alpha;
  } reg_words_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode_ready = 1'b0;
  logic signed [15:0] in_tool_force_z = '0;
  logic signed [15:0] in_wrist_force_x = '0;
  logic signed [15:0] in_wrist_force_y = '0;
  logic signed [15:0] in_wrist_force_z = '0;
  logic signed [15:0] in_wrist_torque_x = '0;
  logic signed [15:0] in_wrist_torque_y = '0;
  logic signed [15:0] in_wrist_torque_z = '0;
  logic [15:0] in_commanded_stiffness_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_command_valid;
  logic signed [15:0] out_add_force_x;
  logic signed [15:0] out_add_force_y;
  logic signed [15:0] out_add_force_z;
  logic signed [15:0] out_add_torque_x;
  logic signed [15:0] out_add_torque_y;
  logic signed [15:0] out_add_torque_z;
  logic [15:0] out_stiffness_z_out;
  logic out_in_contact;
  logic out_impedance_update;
  logic out_mode_request;

  contact_aware_force_amplifier_unit u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_mode_ready            (in_mode_ready),
    .in_tool_force_z          (in_tool_force_z),
    .in_wrist_force_x         (in_wrist_force_x),
    .in_wrist_force_y         (in_wrist_force_y),
    .in_wrist_force_z         (in_wrist_force_z),
    .in_wrist_torque_x        (in_wrist_torque_x),
    .in_wrist_torque_y        (in_wrist_torque_y),
    .in_wrist_torque_z        (in_wrist_torque_z),
    .in_commanded_stiffness_z (in_commanded_stiffness_z),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_command_valid        (out_command_valid),
    .out_add_force_x          (out_add_force_x),
    .out_add_force_y          (out_add_force_y),
    .out_add_force_z          (out_add_force_z),
    .out_add_torque_x         (out_add_torque_x),
    .out_add_torque_y         (out_add_torque_y),
    .out_add_torque_z         (out_add_torque_z),
    .out_stiffness_z_out      (out_stiffness_z_out),
    .out_in_contact           (out_in_contact),
    .out_impedance_update     (out_impedance_update),
    .out_mode_request         (out_mode_request)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and block state
  reg_words_t live_regs;
  logic signed [15:0] bias_z = '0;
  bit bias_held = 1'b0;
  longint filt_z = 0;
  longint thr_active = ACTIVE_THR_RST;
  logic [15:0] stiff_applied = APPLIED_STIFF_RST;
  bit request_sent = 1'b0;

  cafa_res_t wrench_due[$];
  bit pace_on = 1'b1;
  bit hold_active = 1'b0;
  event hold_kick;
  int rx_wait = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned contact_seen = 0;
  int unsigned phases_run = 0;

  function automatic reg_words_t default_regs(bit on);
    reg_words_t rw;
    rw.assist   = {15'd0, on};
    rw.fgain    = FORCE_GAIN_RST;
    rw.tgain    = TORQUE_GAIN_RST;
    rw.flim     = {1'b0, FORCE_LIMIT_RST};
    rw.tlim     = {1'b0, TORQUE_LIMIT_RST};
    rw.thr_in   = THRESH_IN_RST;
    rw.thr_free = THRESH_FREE_RST;
    rw.alpha    = {7'd0, FILTER_ALPHA_RST};
    return rw;
  endfunction

  // divide by 256, halves toward plus infinity
  function automatic longint q8_round(longint s);
    return (s + 128) >>> 8;
  endfunction

  function automatic cafa_res_t predict_wrench(tick_t t);
    cafa_res_t r;
    longint diff, wt, gain, lim, a;
    logic signed [15:0] axis [6];
    logic [15:0] stiff;
    bit touch;
    r = '0;
    if (!live_regs.assist[0]) return r;
    if (!t.mode_ready) begin
      if (!request_sent) begin
        r.mode_request = 1'b1;
        request_sent = 1'b1;
      end
      return r;
    end
    if (!bias_held) begin
      bias_z = t.tool_z;
      bias_held = 1'b1;
      filt_z = 0;
    end
    diff = longint'(t.tool_z) - longint'(bias_z);
    if (diff > 32767) diff = 32767;
    else if (diff < -32768) diff = -32768;
    a = longint'(live_regs.alpha[8:0]);
    if (a > 256) a = 256;
    filt_z = q8_round(a * filt_z + (256 - a) * diff);
    touch = filt_z < thr_active;
    thr_active = touch ? longint'($signed(live_regs.thr_in))
                       : longint'($signed(live_regs.thr_free));
    for (int i = 0; i < 6; i++) begin
      gain = (i < 3) ? longint'($signed(live_regs.fgain)) : longint'($signed(live_regs.tgain));
      lim = (i < 3) ? longint'(live_regs.flim[14:0]) : longint'(live_regs.tlim[14:0]);
      wt = q8_round(longint'(t.wrench[i]) * gain);
      if ((wt < 0) ? (-wt > lim) : (wt > lim)) wt = 0;
      // z force and all torques drop out in contact
      axis[i] = (touch && i >= 2) ? 16'sd0 : wt[15:0];
    end
    stiff = touch ? CONTACT_STIFFNESS : t.stiff_cmd;
    r.command_valid    = 1'b1;
    r.add_force_x      = axis[0];
    r.add_force_y      = axis[1];
    r.add_force_z      = axis[2];
    r.add_torque_x     = axis[3];
    r.add_torque_y     = axis[4];
    r.add_torque_z     = axis[5];
    r.stiffness_z_out  = stiff;
    r.in_contact       = touch;
    r.impedance_update = (stiff != stiff_applied);
    stiff_applied = stiff;
    return r;
  endfunction

  function automatic tick_t build_tick(bit ready, int tz, int f, int tq, int st);
    tick_t t;
    t.mode_ready = ready;
    t.tool_z = 16'(tz);
    for (int i = 0; i < 6; i++) t.wrench[i] = (i < 3) ? 16'(f) : 16'(tq);
    t.stiff_cmd = 16'(st);
    return t;
  endfunction

  // mostly ready ticks hovering around the captured bias, some full-range noise
  function automatic tick_t make_tick();
    tick_t t;
    int pick;
    t.mode_ready = ($urandom_range(0, 99) >= 6);
    pick = $urandom_range(0, 99);
    if (pick < 70) t.tool_z = 16'(int'(bias_z) + int'($urandom_range(0, 2300)) - 1500);
    else if (pick < 85) t.tool_z = 16'($urandom);
    else t.tool_z = 16'(int'(bias_z) + int'($urandom_range(0, 200)) - 100);
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 9) < 6) t.wrench[i] = 16'(int'($urandom_range(0, 6000)) - 3000);
      else t.wrench[i] = 16'($urandom);
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) t.stiff_cmd = CONTACT_STIFFNESS;
    else if (pick < 6) t.stiff_cmd = stiff_applied;
    else t.stiff_cmd = 16'($urandom);
    return t;
  endfunction

  function automatic reg_words_t random_regs();
    reg_words_t rw;
    rw.assist = 16'd1;
    rw.fgain = ($urandom_range(0, 1) != 0) ? 16'(int'($urandom_range(0, 1024)) - 512)
                                           : 16'($urandom);
    rw.tgain = ($urandom_range(0, 1) != 0) ? 16'(int'($urandom_range(0, 1024)) - 512)
                                           : 16'($urandom);
    rw.flim = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(500, 20000));
    rw.tlim = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(50, 5000));
    rw.thr_in = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 300))
                                            : 16'(-int'($urandom_range(0, 2000)));
    rw.thr_free = 16'(-int'($urandom_range(0, 3000)));
    rw.alpha = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    return rw;
  endfunction

  task automatic send_tick(tick_t t);
    int gap;
    gap = pace_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                 <= 1'b1;
    in_mode_ready            <= t.mode_ready;
    in_tool_force_z          <= t.tool_z;
    in_wrist_force_x         <= t.wrench[0];
    in_wrist_force_y         <= t.wrench[1];
    in_wrist_force_z         <= t.wrench[2];
    in_wrist_torque_x        <= t.wrench[3];
    in_wrist_torque_y        <= t.wrench[4];
    in_wrist_torque_z        <= t.wrench[5];
    in_commanded_stiffness_z <= t.stiff_cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    wrench_due.insert(wrench_due.size(), predict_wrench(t));
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (wrench_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(reg_words_t rw);
    drain_results();
    put_reg(REG_ASSIST_ENABLE, rw.assist);
    put_reg(REG_FORCE_GAIN, rw.fgain);
    put_reg(REG_TORQUE_GAIN, rw.tgain);
    put_reg(REG_FORCE_LIMIT, rw.flim);
    put_reg(REG_TORQUE_LIMIT, rw.tlim);
    put_reg(REG_THRESH_IN, rw.thr_in);
    put_reg(REG_THRESH_FREE, rw.thr_free);
    put_reg(REG_FILTER_ALPHA, rw.alpha);
    cfg_we <= 1'b0;
    live_regs = rw;
    phases_run++;
  endtask

  // ---- tests ----

  task automatic test_disabled();
    send_tick(build_tick(1'b1, 32767, -32768, 32767, 65535));
    send_tick(build_tick(1'b0, -32768, 32767, -32768, 0));
  endtask

  task automatic test_mode_request();
    load_regs(default_regs(1'b1));
    send_tick(build_tick(1'b0, 0, 100, 100, 500));
    send_tick(build_tick(1'b0, 0, 100, 100, 500));
  endtask

  task automatic test_bias_and_contact();
    send_tick(build_tick(1'b1, -20000, 0, 0, 1));           // bias capture, no update
    send_tick(build_tick(1'b1, -23000, 1000, 200, 65535));  // enters contact
    send_tick(build_tick(1'b1, -23000, -1000, -200, 100));  // stays in contact
    send_tick(build_tick(1'b1, 32767, 32767, 32767, 0));    // difference saturates
    send_tick(build_tick(1'b1, -20000, -32768, 32767, 65535));
    send_tick(build_tick(1'b0, -20000, 5, 5, 7));           // request already sent
    send_tick(build_tick(1'b1, -20000, 300, -300, 65535));
  endtask

  task automatic poke_extremes();
    send_tick(build_tick(1'b1, int'(bias_z), 1, -1, 0));
    send_tick(build_tick(1'b1, 32767, 32767, 32767, 65535));
    send_tick(build_tick(1'b1, -32768, -32768, -32768, 65535));
  endtask

  task automatic test_register_extremes();
    reg_words_t rw;
    rw = '{assist: 16'd1, fgain: 16'h7fff, tgain: 16'h8000, flim: 16'h7fff, tlim: 16'h7fff,
           thr_in: 16'h8000, thr_free: 16'h8000, alpha: 16'd0};
    load_regs(rw);
    poke_extremes();
    // zero limits, zero thresholds, alpha beyond one (filter frozen)
    rw = '{assist: 16'hffff, fgain: 16'h8000, tgain: 16'h7fff, flim: 16'h0000, tlim: 16'h8000,
           thr_in: 16'd0, thr_free: 16'd0, alpha: 16'hffff};
    load_regs(rw);
    poke_extremes();
    rw = default_regs(1'b1);
    rw.thr_in = 16'd500;
    rw.thr_free = 16'd300;
    rw.alpha = 16'd256;
    rw.tgain = 16'd256;
    load_regs(rw);
    poke_extremes();
  endtask

  task automatic test_backpressure();
    reg_words_t rw;
    rw = default_regs(1'b1);
    rw.tgain = 16'h0180;
    rw.alpha = 16'd128;
    load_regs(rw);
    pace_on = 1'b0;
    -> hold_kick;
    repeat (30) send_tick(make_tick());
    pace_on = 1'b1;
  endtask

  task automatic test_random_ticks();
    reg_words_t rw;
    for (int ph = 0; ph < 8; ph++) begin
      rw = random_regs();
      if (ph == 5) rw.assist = 16'd0;
      pace_on = (ph % 3 != 1);
      load_regs(rw);
      repeat (60) send_tick(make_tick());
    end
    pace_on = 1'b1;
  endtask

  // ---- receiver pacing and long hold-off ----

  initial begin
    forever begin
      @(hold_kick);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (hold_active) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_wait = pace_on ? $urandom_range(0, 19) : 0;
      out_stall <= (rx_wait != 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= (rx_wait != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---- result checking ----

  task automatic judge(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d %s: expected %h actual %h", results_seen, field, want, got);
    end
  endtask

  always @(posedge clk) begin : wrench_checker
    cafa_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_in_contact === 1'b1) contact_seen++;
      if (wrench_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = wrench_due.pop_front();
        judge("command_valid", want.command_valid, out_command_valid);
        judge("add_force_x", want.add_force_x, out_add_force_x);
        judge("add_force_y", want.add_force_y, out_add_force_y);
        judge("add_force_z", want.add_force_z, out_add_force_z);
        judge("add_torque_x", want.add_torque_x, out_add_torque_x);
        judge("add_torque_y", want.add_torque_y, out_add_torque_y);
        judge("add_torque_z", want.add_torque_z, out_add_torque_z);
        judge("stiffness_z_out", want.stiffness_z_out, out_stiffness_z_out);
        judge("in_contact", want.in_contact, out_in_contact);
        judge("impedance_update", want.impedance_update, out_impedance_update);
        judge("mode_request", want.mode_request, out_mode_request);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", wrench_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    live_regs = default_regs(1'b0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    test_mode_request();
    test_bias_and_contact();
    test_register_extremes();
    test_backpressure();
    test_random_ticks();
    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d ticks over %0d register settings, %0d results checked, %0d in contact",
             ticks_sent, phases_run, results_seen, contact_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[contact_aware_force_amplifier_unit.f]
rtl/cafa_pkg.sv
rtl/cafa_axis.sv
rtl/contact_aware_force_amplifier_unit.sv
rtl/cafa_chk.sv
verif/contact_aware_force_amplifier_unit_test.sv
